@@ rtl/composite_bounds_fold_macros.svh @@
// Assertion macros for the composite bounds fold block.
// Needs nothing else; taken in by the files that assert.
`ifndef COMPOSITE_BOUNDS_FOLD_MACROS_SVH
`define COMPOSITE_BOUNDS_FOLD_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define CBF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under synchronous reset.
`define CBF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cbf_pkg.sv @@
// Shared types, mode codes and edge helpers for the composite bounds fold.
// No dependencies.
package cbf_pkg;

   localparam int EDGE_W = 32;
   localparam int MODE_W = 4;

   typedef logic signed [EDGE_W-1:0] coord_type;
   typedef logic [MODE_W-1:0]        mode_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } rect_type;

   typedef struct packed {
      rect_type rect;
      logic     last;
   } beat_type;

   localparam mode_type MODE_SOURCE_OVER      = 4'd0;
   localparam mode_type MODE_DESTINATION_OVER = 4'd1;
   localparam mode_type MODE_SOURCE_IN        = 4'd2;
   localparam mode_type MODE_DESTINATION_IN   = 4'd3;
   localparam mode_type MODE_SOURCE_OUT       = 4'd4;
   localparam mode_type MODE_DESTINATION_OUT  = 4'd5;
   localparam mode_type MODE_SOURCE_ATOP      = 4'd6;
   localparam mode_type MODE_DESTINATION_ATOP = 4'd7;
   localparam mode_type MODE_XOR              = 4'd8;
   localparam mode_type MODE_PLUS             = 4'd9;
   localparam mode_type MODE_SOURCE_COPY      = 4'd10;
   localparam mode_type MODE_BOUNDED_COPY     = 4'd11;
   localparam mode_type MODE_MASK_INVERT      = 4'd12;

   function automatic coord_type coord_min(coord_type a, coord_type b);
      return (b < a) ? b : a;
   endfunction

   function automatic coord_type coord_max(coord_type a, coord_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic logic rect_empty(rect_type r);
      return (r.left >= r.right) || (r.top >= r.bottom);
   endfunction

endpackage

@@ rtl/cbf_in_stage.sv @@
// Input register of the composite bounds fold: captures one rectangle beat.
// Depends on cbf_pkg.
module cbf_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  cbf_pkg::beat_type req_beat,
   output logic             req_stall,
   input  logic             take,
   output logic             valid,
   output cbf_pkg::beat_type beat
);
   import cbf_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff;
   logic     accept;

   // Stall only while a held beat cannot move on this cycle.
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff <= req_beat;
      end
   end

   assign valid = valid_ff;
   assign beat  = beat_ff;

endmodule

@@ rtl/cbf_fold.sv @@
// Bounds accumulator and combine logic: folds each source rectangle into the
// running bounds by composite mode. Depends on cbf_pkg.
module cbf_fold (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  cbf_pkg::beat_type beat,
   input  cbf_pkg::mode_type mode,
   output cbf_pkg::rect_type result
);
   import cbf_pkg::*;

   rect_type acc_ff, acc_in;
   logic     first_ff, first_in;
   rect_type src, comb;

   assign src = beat.rect;

   always_comb begin
      comb = acc_ff;
      unique case (mode)
         MODE_SOURCE_IN, MODE_DESTINATION_IN: begin
            comb.left   = coord_max(acc_ff.left, src.left);
            comb.top    = coord_max(acc_ff.top, src.top);
            comb.right  = coord_min(acc_ff.right, src.right);
            comb.bottom = coord_min(acc_ff.bottom, src.bottom);
         end
         MODE_SOURCE_OUT, MODE_DESTINATION_ATOP, MODE_SOURCE_COPY: begin
            comb = src;
         end
         MODE_DESTINATION_OUT, MODE_SOURCE_ATOP: begin
            comb = acc_ff;
         end
         default: begin
            // Union; an empty side gives way to the other.
            if (rect_empty(src)) begin
               comb = acc_ff;
            end else if (rect_empty(acc_ff)) begin
               comb = src;
            end else begin
               comb.left   = coord_min(acc_ff.left, src.left);
               comb.top    = coord_min(acc_ff.top, src.top);
               comb.right  = coord_max(acc_ff.right, src.right);
               comb.bottom = coord_max(acc_ff.bottom, src.bottom);
            end
         end
      endcase
   end

   always_comb begin
      // First rectangle of a run goes in untouched, even when empty.
      if (first_ff) begin
         result = src;
      end else if (rect_empty(comb)) begin
         result = '0;
      end else begin
         result = comb;
      end
   end

   assign acc_in   = take ? result : acc_ff;
   assign first_in = take ? beat.last : first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         first_ff <= 1'b1;
      end else begin
         acc_ff   <= acc_in;
         first_ff <= first_in;
      end
   end

endmodule

@@ rtl/cbf_out_stage.sv @@
// Result register of the composite bounds fold: holds a bounds beat until
// the receiver takes it. Depends on cbf_pkg.
module cbf_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  cbf_pkg::beat_type data,
   output logic             can_take,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cbf_pkg::beat_type rsp_beat
);
   import cbf_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff;

   assign can_take = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         beat_ff <= data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

@@ rtl/composite_bounds_fold.sv @@
// Top level of the composite bounds fold: mode register, input register,
// combine logic and result register. Depends on cbf_pkg and the macro header.
//
// Usage:
//   req_ channel: one rectangle per beat (signed 32-bit edges, right and
//   bottom exclusive) with req_last_of_run closing a run. rsp_ channel: one
//   beat of running bounds per request beat, in order, rsp_is_final echoing
//   last_of_run. csr_ channel: writes the 4-bit composite mode; csr_ready is
//   always high. Change the mode only while no beat is in flight.
//   A beat passes the input and then the result register. Throughput is one
//   rectangle per cycle while the receiver does not stall: the accumulator
//   closes its loop through one compare-and-select per edge between the input
//   and result registers. Reset clears the bounds to zero, sets the mode to
//   source_over and makes the next beat start a run. When the receiver
//   stalls, the result register holds its beat and the input register takes
//   one more; after that req_stall rises until the response moves.
`include "composite_bounds_fold_macros.svh"
module composite_bounds_fold (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cbf_pkg::coord_type req_in_left,
   input  cbf_pkg::coord_type req_in_top,
   input  cbf_pkg::coord_type req_in_right,
   input  cbf_pkg::coord_type req_in_bottom,
   input  logic               req_last_of_run,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cbf_pkg::coord_type rsp_out_left,
   output cbf_pkg::coord_type rsp_out_top,
   output cbf_pkg::coord_type rsp_out_right,
   output cbf_pkg::coord_type rsp_out_bottom,
   output logic               rsp_is_final,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  cbf_pkg::mode_type  csr_data
);
   import cbf_pkg::*;

   mode_type mode_ff, mode_in;
   beat_type req_beat, in_beat, out_data, out_beat;
   logic     in_valid, can_take, take;
   rect_type result;

   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SOURCE_OVER;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign req_beat.rect.left   = req_in_left;
   assign req_beat.rect.top    = req_in_top;
   assign req_beat.rect.right  = req_in_right;
   assign req_beat.rect.bottom = req_in_bottom;
   assign req_beat.last        = req_last_of_run;

   // Advance a held rectangle whenever the result register can accept it.
   assign take = in_valid && can_take;

   cbf_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_beat  (req_beat),
      .req_stall (req_stall),
      .take      (take),
      .valid     (in_valid),
      .beat      (in_beat)
   );

   cbf_fold u_fold (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .beat   (in_beat),
      .mode   (mode_ff),
      .result (result)
   );

   assign out_data.rect = result;
   assign out_data.last = in_beat.last;

   cbf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data      (out_data),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (out_beat)
   );

   assign rsp_out_left   = out_beat.rect.left;
   assign rsp_out_top    = out_beat.rect.top;
   assign rsp_out_right  = out_beat.rect.right;
   assign rsp_out_bottom = out_beat.rect.bottom;
   assign rsp_is_final   = out_beat.last;

   `CBF_ASSERT_IMP(a_stall_needs_held, clock, reset, req_stall, in_valid, "stall with empty input register")
   `CBF_ASSERT_IMP(a_full_blocks, clock, reset, rsp_valid && rsp_stall && in_valid, req_stall, "input taken while both registers full")
   `CBF_ASSERT_NXT(a_take_shows, clock, reset, take, rsp_valid, "advanced beat not presented")
   `CBF_ASSERT_NXT(a_final_echo, clock, reset, take, rsp_is_final == $past(in_beat.last), "final flag lost")

endmodule

@@ tb/composite_bounds_fold_tb.sv @@
// Self-checking bench for composite_bounds_fold: directed and random rectangle runs
// over every mode, with random idling on both channels, checked against a bounds fold.
// Depends on cbf_pkg and the composite_bounds_fold RTL.
module composite_bounds_fold_tb;
   import cbf_pkg::*;

   localparam coord_type EDGE_MIN = 32'sh8000_0000;
   localparam coord_type EDGE_MAX = 32'sh7FFF_FFFF;
   localparam mode_type MODE_UNUSED_LO  = 4'd13;
   localparam mode_type MODE_UNUSED_MID = 4'd14;
   localparam mode_type MODE_UNUSED_HI  = 4'd15;
   localparam int TIMEOUT = 2_000_000;
   localparam int PHASE_BEATS = 25;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   coord_type req_in_left = '0;
   coord_type req_in_top = '0;
   coord_type req_in_right = '0;
   coord_type req_in_bottom = '0;
   logic      req_last_of_run = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   coord_type rsp_out_left;
   coord_type rsp_out_top;
   coord_type rsp_out_right;
   coord_type rsp_out_bottom;
   logic      rsp_is_final;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   mode_type  csr_data = MODE_SOURCE_OVER;

   // Shadow of the block's state
   rect_type  acc_bounds = '0;
   logic      starts_run = 1'b1;
   mode_type  mode_shadow = MODE_SOURCE_OVER;
   beat_type  bounds_due[$];

   int mismatches = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int stall_hold = 0;

   composite_bounds_fold dut (.*);

   always #6 clock = ~clock;

   function automatic logic is_void(rect_type r);
      return !((r.left < r.right) && (r.top < r.bottom));
   endfunction

   function automatic coord_type lesser(coord_type a, coord_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic coord_type greater(coord_type a, coord_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic void fold_bounds(rect_type src, logic last);
      if (starts_run) begin
         acc_bounds = src;
      end else begin
         case (mode_shadow)
            MODE_SOURCE_IN, MODE_DESTINATION_IN: begin
               acc_bounds.left   = greater(acc_bounds.left, src.left);
               acc_bounds.top    = greater(acc_bounds.top, src.top);
               acc_bounds.right  = lesser(acc_bounds.right, src.right);
               acc_bounds.bottom = lesser(acc_bounds.bottom, src.bottom);
            end
            MODE_SOURCE_OUT, MODE_DESTINATION_ATOP, MODE_SOURCE_COPY: begin
               acc_bounds = src;
            end
            MODE_DESTINATION_OUT, MODE_SOURCE_ATOP: begin
            end
            default: begin
               if (!is_void(src)) begin
                  if (is_void(acc_bounds)) begin
                     acc_bounds = src;
                  end else begin
                     acc_bounds.left   = lesser(acc_bounds.left, src.left);
                     acc_bounds.top    = lesser(acc_bounds.top, src.top);
                     acc_bounds.right  = greater(acc_bounds.right, src.right);
                     acc_bounds.bottom = greater(acc_bounds.bottom, src.bottom);
                  end
               end
            end
         endcase
         if (is_void(acc_bounds)) acc_bounds = '0;
      end
      starts_run = last;
      bounds_due.push_back('{acc_bounds, last});
   endfunction

   function automatic coord_type pick_edge();
      case ($urandom_range(4))
         0: return EDGE_MIN;
         1: return EDGE_MAX;
         2: return coord_type'(0);
         3: return coord_type'(-1);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Mostly small overlapping rectangles, some empty; the rest wide or extreme
   function automatic rect_type random_rect();
      rect_type r;
      int kind;
      kind = $urandom_range(9);
      if (kind < 6) begin
         r.left   = coord_type'(int'($urandom_range(200)) - 100);
         r.top    = coord_type'(int'($urandom_range(200)) - 100);
         r.right  = r.left + coord_type'(int'($urandom_range(60)) - 5);
         r.bottom = r.top + coord_type'(int'($urandom_range(60)) - 5);
      end else begin
         r.left   = pick_edge();
         r.top    = pick_edge();
         r.right  = pick_edge();
         r.bottom = pick_edge();
      end
      return r;
   endfunction

   function automatic void check_field(string name, coord_type want, coord_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Receiver: a requested hold-off wins over random stalls
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      beat_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bounds_due.size() == 0) begin
            $error("response beat with no bounds due");
            mismatches++;
         end else begin
            due = bounds_due.pop_front();
            check_field("out_left", due.rect.left, rsp_out_left);
            check_field("out_top", due.rect.top, rsp_out_top);
            check_field("out_right", due.rect.right, rsp_out_right);
            check_field("out_bottom", due.rect.bottom, rsp_out_bottom);
            check_field("is_final", coord_type'(due.last), coord_type'(rsp_is_final));
         end
      end
   end

   // Called at a clock edge; returns at the edge that accepts the beat
   task automatic send_rect(rect_type r, logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_in_left     <= r.left;
      req_in_top      <= r.top;
      req_in_right    <= r.right;
      req_in_bottom   <= r.bottom;
      req_last_of_run <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
      fold_bounds(r, last);
   endtask

   // Drop valid and hold until every pending beat has come back
   task automatic wait_for_bounds();
      req_valid <= 1'b0;
      do @(posedge clock); while (bounds_due.size() != 0);
   endtask

   task automatic write_mode(mode_type m);
      wait_for_bounds();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      mode_shadow = m;
   endtask

   // Reset mode is source_over; first beats of a run are copied, even when empty
   task automatic test_first_of_run();
      send_rect('{EDGE_MIN, EDGE_MIN, EDGE_MAX, EDGE_MAX}, 1'b1);
      send_rect('{32'sd5, 32'sd5, -32'sd5, -32'sd5}, 1'b1);
      send_rect('{EDGE_MAX, EDGE_MAX, EDGE_MIN, EDGE_MIN}, 1'b0);
      send_rect('{32'sd0, 32'sd0, 32'sd1, 32'sd1}, 1'b1);
   endtask

   task automatic test_union_rules();
      write_mode(MODE_XOR);
      send_rect('{-32'sd10, -32'sd10, 32'sd10, 32'sd10}, 1'b0);
      send_rect('{32'sd3, 32'sd3, 32'sd3, 32'sd9}, 1'b0);
      send_rect('{EDGE_MIN, 32'sd0, 32'sd0, EDGE_MAX}, 1'b0);
      send_rect('{EDGE_MAX, EDGE_MIN, EDGE_MIN, EDGE_MAX}, 1'b0);
      send_rect('{-32'sd1, -32'sd1, EDGE_MAX, EDGE_MAX}, 1'b1);
   endtask

   task automatic test_intersect_rules();
      write_mode(MODE_SOURCE_IN);
      send_rect('{32'sd0, 32'sd0, 32'sd10, 32'sd10}, 1'b0);
      send_rect('{32'sd5, -32'sd5, 32'sd20, 32'sd8}, 1'b0);
      // disjoint: bounds collapse to zero
      send_rect('{32'sd20, 32'sd20, 32'sd30, 32'sd30}, 1'b0);
      send_rect('{32'sd1, 32'sd1, 32'sd2, 32'sd2}, 1'b1);
   endtask

   // Replace and keep, with the mode changed twice inside one open run
   task automatic test_mode_change_in_run();
      write_mode(MODE_SOURCE_COPY);
      send_rect('{32'sd1, 32'sd2, 32'sd3, 32'sd4}, 1'b0);
      send_rect('{32'sd9, 32'sd8, 32'sd7, 32'sd6}, 1'b0);
      send_rect('{-32'sd3, -32'sd3, 32'sd3, 32'sd3}, 1'b0);
      write_mode(MODE_DESTINATION_OUT);
      send_rect('{32'sd50, 32'sd50, 32'sd60, 32'sd60}, 1'b0);
      write_mode(MODE_UNUSED_HI);
      send_rect('{-32'sd8, -32'sd8, 32'sd1, 32'sd1}, 1'b1);
   endtask

   // Hold the response side so the block fills and stalls its input
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_mode(MODE_SOURCE_OVER);
      stall_hold = 40;
      repeat (16) send_rect(random_rect(), $urandom_range(3) == 0);
      wait_for_bounds();
   endtask

   task automatic test_random_runs();
      mode_type sweep[16];
      int run_left;
      sweep = '{MODE_SOURCE_OVER, MODE_DESTINATION_OVER, MODE_SOURCE_IN,
                MODE_DESTINATION_IN, MODE_SOURCE_OUT, MODE_DESTINATION_OUT,
                MODE_SOURCE_ATOP, MODE_DESTINATION_ATOP, MODE_XOR, MODE_PLUS,
                MODE_SOURCE_COPY, MODE_BOUNDED_COPY, MODE_MASK_INVERT,
                MODE_UNUSED_LO, MODE_UNUSED_MID, MODE_UNUSED_HI};
      run_left = 0;
      foreach (sweep[i]) begin
         if (i < 6) begin
            send_idle_pct = 35;
            stall_pct     = 68;
         end else if (i < 11) begin
            send_idle_pct = 68;
            stall_pct     = 35;
         end else begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         // an open run carries over into the next mode
         write_mode(sweep[i]);
         repeat (PHASE_BEATS) begin
            if (run_left == 0) run_left = $urandom_range(1, 6);
            run_left--;
            send_rect(random_rect(), run_left == 0);
            if ($urandom_range(19) == 0) wait_for_bounds();
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_first_of_run();
      test_union_rules();
      test_intersect_rules();
      test_mode_change_in_run();
      test_backpressure();
      test_random_runs();
      wait_for_bounds();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #TIMEOUT;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ composite_bounds_fold.f @@
+incdir+rtl
rtl/cbf_pkg.sv
rtl/cbf_in_stage.sv
rtl/cbf_fold.sv
rtl/cbf_out_stage.sv
rtl/composite_bounds_fold.sv
tb/composite_bounds_fold_tb.sv
